### src/spli_pkg.sv
`timescale 1ns / 1ps

package spli_pkg;

   // field widths of the stream words
   localparam int OP_BITS      = 2;
   localparam int ADDR_BITS    = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int OFFSET_BITS  = 12;
   localparam int CH_BITS      = 3;
   localparam int CC_BITS      = 4;
   localparam int LEN_BITS     = 17;
   localparam int RATE_BITS    = 24;
   localparam int FRAC_BITS    = 16;
   localparam int HEAD_BITS    = 33;

   // sample memory
   localparam int SAMPLE_WORDS = 65536;
   localparam int MAX_CHANNELS = 8;

   // derived widths
   localparam int PROD_BITS    = OFFSET_BITS + RATE_BITS;
   localparam int POS_BITS     = PROD_BITS + 1;
   localparam int WADDR_BITS   = LEN_BITS + CC_BITS;
   localparam int WEIGHT_BITS  = FRAC_BITS + 1;
   localparam int MUL_BITS     = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int SUM_BITS     = MUL_BITS + 1;

   // stream packing
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 24;

   // queue
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ADVANCE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NONE    = 2'd3;

   // register indexes
   localparam logic [1:0] REG_CHANNELS = 2'd0;
   localparam logic [1:0] REG_LENGTH   = 2'd1;
   localparam logic [1:0] REG_RATE     = 2'd2;
   localparam logic [1:0] REG_LOOPING  = 2'd3;

   // register reset values
   localparam logic [CC_BITS-1:0]   CHANNELS_RESET = 4'd1;
   localparam logic [LEN_BITS-1:0]  LENGTH_RESET   = 17'd65536;
   localparam logic [RATE_BITS-1:0] RATE_RESET     = 24'd65536;

   typedef struct packed {
      logic [CC_BITS-1:0]   channel_count;
      logic [LEN_BITS-1:0]  length_frames;
      logic [RATE_BITS-1:0] rate_ratio;
      logic                 looping;
   } cfg_type;

   // one classified word between front and back
   typedef struct packed {
      logic [OP_BITS-1:0]            op;
      logic [ADDR_BITS-1:0]          addr;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [CH_BITS-1:0]            channel;
      logic [PROD_BITS-1:0]          prod;
   } entry_type;

endpackage

### src/spli_fifo.sv
`timescale 1ns / 1ps

module spli_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  spli_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output spli_pkg::entry_type pop_data
);
   import spli_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/spli_front.sv
`timescale 1ns / 1ps

module spli_front (
   input  logic                                clock,
   input  logic                                reset,
   input  spli_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [spli_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [spli_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                push_valid,
   input  logic                                push_ready,
   output spli_pkg::entry_type                 push_data
);
   import spli_pkg::*;

   logic                         hold_valid_ff, hold_valid_in;
   logic [OP_BITS-1:0]           hold_op_ff;
   logic [REQ_DATA_BITS-1:0]     hold_data_ff;
   logic                         hold_done;
   logic                         hold_drop;
   logic [OFFSET_BITS-1:0]       frames;

   // unpack: address, value, offset, channel, advance frames
   assign hold_drop = (hold_op_ff == OP_NONE);
   assign frames    = (hold_op_ff == OP_READ) ? hold_data_ff[43:32] : hold_data_ff[58:47];

   assign push_valid        = hold_valid_ff && !hold_drop;
   assign push_data.op      = hold_op_ff;
   assign push_data.addr    = hold_data_ff[15:0];
   assign push_data.value   = $signed(hold_data_ff[31:16]);
   assign push_data.channel = hold_data_ff[46:44];
   assign push_data.prod    = PROD_BITS'(frames) * PROD_BITS'(cfg.rate_ratio);

   assign hold_done  = hold_valid_ff && (hold_drop || push_ready);
   assign req_tready = !hold_valid_ff || hold_done;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
      end else if (hold_done) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // capture accepted word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_op_ff   <= req_tuser;
         hold_data_ff <= req_tdata;
      end
   end

endmodule

### src/spli_back.sv
`timescale 1ns / 1ps

module spli_back (
   input  logic                                clock,
   input  logic                                reset,
   input  spli_pkg::cfg_type                   cfg,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  spli_pkg::entry_type                 pop_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [spli_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tuser
);
   import spli_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADDR  = 3'd1;
   localparam logic [2:0] ST_RD_LO = 3'd2;
   localparam logic [2:0] ST_RD_HI = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_ADV   = 3'd6;

   localparam logic [HEAD_BITS-1:0]   HEAD_MAX = '1;
   localparam logic [WEIGHT_BITS-1:0] ONE      = WEIGHT_BITS'(1) << FRAC_BITS;
   localparam logic [SUM_BITS-1:0]    HALF     = SUM_BITS'(1) << (FRAC_BITS - 1);

   logic [2:0]                     state_ff, state_in;
   logic [HEAD_BITS-1:0]           head_ff, head_in;
   logic [POS_BITS-1:0]            pos_ff, pos_in;
   logic [PROD_BITS-1:0]           block_ff, block_in;
   logic [CH_BITS-1:0]             chan_ff, chan_in;
   logic [WADDR_BITS-1:0]          lo_addr_ff, lo_addr_in;
   logic [WADDR_BITS-1:0]          hi_addr_ff, hi_addr_in;
   logic [FRAC_BITS-1:0]           frac_ff, frac_in;
   logic                           lo_zero_ff, lo_zero_in;
   logic                           hi_zero_ff, hi_zero_in;
   logic signed [SAMPLE_BITS-1:0]  lo_ff, lo_in;
   logic signed [MUL_BITS-1:0]     mul_lo_ff, mul_lo_in;
   logic signed [MUL_BITS-1:0]     mul_hi_ff, mul_hi_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]       rsp_data_ff, rsp_data_in;
   logic                           rsp_adv_ff, rsp_adv_in;

   logic signed [SAMPLE_BITS-1:0]  sample_mem_ff [SAMPLE_WORDS];
   logic signed [SAMPLE_BITS-1:0]  mem_q_ff;
   logic [ADDR_BITS-1:0]           rd_addr;
   logic                           mem_we;

   logic                           out_free;
   logic                           pop_fire;
   logic [POS_BITS-1:0]            end_pos;
   logic [POS_BITS-1:0]            head_sum;
   logic [POS_BITS-1:0]            next_sum;
   logic                           past;
   logic                           reached;
   logic [CC_BITS-1:0]             cc;
   logic [CC_BITS-1:0]             ch_eff;
   logic [LEN_BITS-1:0]            lo_f;
   logic [LEN_BITS:0]              hi_f;
   logic [LEN_BITS-1:0]            hi_clamp;
   logic signed [SAMPLE_BITS-1:0]  hi_val;
   logic [SUM_BITS-1:0]            sum;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign mem_we    = pop_fire && (pop_data.op == OP_LOAD);

   assign end_pos  = POS_BITS'({cfg.length_frames, {FRAC_BITS{1'b0}}});
   assign head_sum = POS_BITS'(head_ff) + POS_BITS'(pop_data.prod);
   assign next_sum = POS_BITS'(head_ff) + POS_BITS'(block_ff);
   assign past     = (pos_ff >= end_pos);
   assign reached  = (next_sum >= end_pos);

   // effective channel count and clamped channel
   always_comb begin
      if (cfg.channel_count == '0) begin
         cc = CC_BITS'(1);
      end else if (cfg.channel_count > CC_BITS'(MAX_CHANNELS)) begin
         cc = CC_BITS'(MAX_CHANNELS);
      end else begin
         cc = cfg.channel_count;
      end
      if (CC_BITS'(chan_ff) > cc - 1'b1) begin
         ch_eff = cc - 1'b1;
      end else begin
         ch_eff = CC_BITS'(chan_ff);
      end
   end

   // floor and ceiling frames, ceiling held at the last frame
   assign lo_f = pos_ff[FRAC_BITS +: LEN_BITS];
   assign hi_f = (LEN_BITS + 1)'(lo_f) + (LEN_BITS + 1)'(pos_ff[FRAC_BITS-1:0] != '0);
   assign hi_clamp = (hi_f > (LEN_BITS + 1)'(cfg.length_frames - 1'b1)) ?
                     cfg.length_frames - 1'b1 : hi_f[LEN_BITS-1:0];

   assign hi_val = hi_zero_ff ? '0 : mem_q_ff;
   assign sum    = SUM_BITS'(mul_lo_ff) + SUM_BITS'(mul_hi_ff) + HALF;
   assign rd_addr = (state_ff == ST_RD_LO) ? lo_addr_ff[ADDR_BITS-1:0]
                                           : hi_addr_ff[ADDR_BITS-1:0];

   // sequence one word at a time
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      block_in     = block_ff;
      chan_in      = chan_ff;
      lo_addr_in   = lo_addr_ff;
      hi_addr_in   = hi_addr_ff;
      frac_in      = frac_ff;
      lo_zero_in   = lo_zero_ff;
      hi_zero_in   = hi_zero_ff;
      lo_in        = lo_ff;
      mul_lo_in    = mul_lo_ff;
      mul_hi_in    = mul_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_adv_in   = rsp_adv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_fire) begin
               case (pop_data.op)
                  OP_READ: begin
                     pos_in   = POS_BITS'(head_ff) + POS_BITS'(pop_data.prod);
                     chan_in  = pop_data.channel;
                     state_in = ST_ADDR;
                  end
                  OP_ADVANCE: begin
                     block_in = pop_data.prod;
                     head_in  = (head_sum > POS_BITS'(HEAD_MAX)) ? HEAD_MAX
                                                                 : head_sum[HEAD_BITS-1:0];
                     state_in = ST_ADV;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADDR: begin
            if (past) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = RSP_DATA_BITS'(1) << SAMPLE_BITS;
                  rsp_adv_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               lo_addr_in = WADDR_BITS'(lo_f) * WADDR_BITS'(cc) + WADDR_BITS'(ch_eff);
               hi_addr_in = WADDR_BITS'(hi_clamp) * WADDR_BITS'(cc) + WADDR_BITS'(ch_eff);
               frac_in    = pos_ff[FRAC_BITS-1:0];
               state_in   = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            lo_zero_in = (lo_addr_ff >= WADDR_BITS'(SAMPLE_WORDS));
            state_in   = ST_RD_HI;
         end
         ST_RD_HI: begin
            lo_in      = lo_zero_ff ? '0 : mem_q_ff;
            hi_zero_in = (hi_addr_ff >= WADDR_BITS'(SAMPLE_WORDS));
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            mul_lo_in = lo_ff * $signed({1'b0, ONE - WEIGHT_BITS'(frac_ff)});
            mul_hi_in = hi_val * $signed({2'b00, frac_ff});
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'(sum[FRAC_BITS +: SAMPLE_BITS]);
               rsp_adv_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_ADV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'(reached) << (SAMPLE_BITS + 1);
               rsp_adv_in   = 1'b1;
               if (reached && cfg.looping) begin
                  head_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold working values
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      block_ff    <= block_in;
      chan_ff     <= chan_in;
      lo_addr_ff  <= lo_addr_in;
      hi_addr_ff  <= hi_addr_in;
      frac_ff     <= frac_in;
      lo_zero_ff  <= lo_zero_in;
      hi_zero_ff  <= hi_zero_in;
      lo_ff       <= lo_in;
      mul_lo_ff   <= mul_lo_in;
      mul_hi_ff   <= mul_hi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_adv_ff  <= rsp_adv_in;
   end

   // sample memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem_ff[pop_data.addr] <= pop_data.value;
      end
      mem_q_ff <= sample_mem_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_adv_ff;

endmodule

### src/sample_player_linear_interp_top.sv
// A read steps the back sequencer through address setup, two reads of the sample memory
//   through its single read port, one multiply stage and one sum stage; a read past the end
//   answers from address setup, an advance passes the advance state, a load is written in idle.
// The front captures the next word and a 4-word queue buffers words meanwhile.
// Reset is synchronous and active high: play head, queue and handshakes clear,
//   registers take their defaults; sample memory is not cleared.
`timescale 1ns / 1ps

module sample_player_linear_interp_top (
   input  logic                                clock,
   input  logic                                reset,
   // tuser: operation[1:0]
   // tdata: load_address[15:0], load_value[31:16], frame_offset[43:32],
   //        channel[46:44], advance_frames[58:47], zero[63:59]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [spli_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [spli_pkg::OP_BITS-1:0]        req_tuser,
   // tdata: sample_out[15:0], past_end[16], reached_end[17], zero[23:18]
   // tuser: is_advance[0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [spli_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [3:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import spli_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic       push_valid, push_ready;
   entry_type  push_data;
   logic       pop_valid, pop_ready;
   entry_type  pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_CHANNELS: cfg_in.channel_count = csr_pwdata[CC_BITS-1:0];
            REG_LENGTH:   cfg_in.length_frames = csr_pwdata[LEN_BITS-1:0];
            REG_RATE:     cfg_in.rate_ratio    = csr_pwdata[RATE_BITS-1:0];
            REG_LOOPING:  cfg_in.looping       = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= CHANNELS_RESET;
         cfg_ff.length_frames <= LENGTH_RESET;
         cfg_ff.rate_ratio    <= RATE_RESET;
         cfg_ff.looping       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[3:2])
         REG_CHANNELS: csr_prdata = 32'(cfg_ff.channel_count);
         REG_LENGTH:   csr_prdata = 32'(cfg_ff.length_frames);
         REG_RATE:     csr_prdata = 32'(cfg_ff.rate_ratio);
         REG_LOOPING:  csr_prdata = 32'(cfg_ff.looping);
         default:      csr_prdata = '0;
      endcase
   end

   spli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   spli_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   spli_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // advance words carry no sample and no past-end flag
   a_adv_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == '0 && !rsp_tdata[16])
      else $error("advance response carries read fields");

   // a read past the end answers silence
   a_past_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == '0 && !rsp_tuser)
      else $error("past-end read gives a nonzero sample");

   // read words never flag reaching the end
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tdata[17])
      else $error("read response flags reached end");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !pop_ready == 1'b0)
      else $error("response or busy back end after reset");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import spli_pkg::*;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          PHASE_WORDS  = 170;
   localparam logic [63:0] HEAD_MAX     = (64'd1 << HEAD_BITS) - 64'd1;
   localparam logic [63:0] UNIT_POS     = 64'd1 << FRAC_BITS;

   // one result word as the block should answer it
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_out;
      logic                   past_end;
      logic                   reached_end;
      logic                   is_advance;
   } voice_answer_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic [OP_BITS-1:0]       req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [3:0]               csr_paddr   = '0;
   logic [31:0]              csr_pwdata  = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   sample_player_linear_interp_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted voice state and settings
   logic [CC_BITS-1:0]            cfg_channels = CHANNELS_RESET;
   logic [LEN_BITS-1:0]           cfg_length   = LENGTH_RESET;
   logic [RATE_BITS-1:0]          cfg_rate     = RATE_RESET;
   logic                          cfg_looping  = 1'b0;
   logic [63:0]                   head_pos     = '0;
   logic                          end_seen     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] voice_mem [SAMPLE_WORDS];
   bit                            mem_loaded [SAMPLE_WORDS];

   voice_answer_type voice_answers [$];
   voice_answer_type got_answer;
   voice_answer_type want_answer;

   int error_count  = 0;
   int cycle_count  = 0;
   int burst_left   = 0;
   bit gaps_off     = 1'b0;
   int hold_request = 0;
   int hold_left    = 0;
   int mode_left    = 0;
   logic [15:0] ready_pattern = 16'hFFFF;

   initial begin
      forever #5 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, voice_answers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function automatic logic [63:0] channels_used();
      if (cfg_channels == 0) return 64'd1;
      if (cfg_channels > MAX_CHANNELS) return 64'(MAX_CHANNELS);
      return {60'd0, cfg_channels};
   endfunction

   // find the floor and ceiling words of a read at the current play head
   function automatic void locate_frames(input logic [OFFSET_BITS-1:0] offset,
                                         input logic [CH_BITS-1:0] chan,
                                         output logic in_range, output logic [63:0] word_lo,
                                         output logic [63:0] word_hi, output logic [63:0] frac);
      logic [63:0] pos, len64, rate64, off64, cc, ch, lo_f, hi_f;
      len64    = {47'd0, cfg_length};
      rate64   = {40'd0, cfg_rate};
      off64    = {52'd0, offset};
      pos      = head_pos + off64 * rate64;
      in_range = pos < (len64 << FRAC_BITS);
      cc       = channels_used();
      ch       = {61'd0, chan};
      if (ch > cc - 1) ch = cc - 1;
      lo_f = pos >> FRAC_BITS;
      frac = pos & (UNIT_POS - 1);
      hi_f = lo_f + ((frac != 0) ? 64'd1 : 64'd0);
      if (hi_f > len64 - 1) hi_f = len64 - 1;
      word_lo = lo_f * cc + ch;
      word_hi = hi_f * cc + ch;
   endfunction

   function automatic logic signed [63:0] fetch_word(input logic [63:0] addr);
      if (addr >= SAMPLE_WORDS) return 64'sd0;
      return 64'(voice_mem[addr[15:0]]);
   endfunction

   // update the predicted state for one accepted word, queue its answer for reads and advances
   task automatic voice_predict(input logic [OP_BITS-1:0] op, input logic [ADDR_BITS-1:0] addr,
                                input logic [SAMPLE_BITS-1:0] value,
                                input logic [OFFSET_BITS-1:0] offset,
                                input logic [CH_BITS-1:0] chan,
                                input logic [OFFSET_BITS-1:0] frames);
      voice_answer_type   ans;
      logic               in_range;
      logic [63:0]        w_lo, w_hi, frac, block, end_pos;
      logic signed [63:0] s_lo, s_hi, wt_lo, wt_hi, acc;
      ans     = '0;
      end_pos = {47'd0, cfg_length} << FRAC_BITS;
      case (op)
         OP_LOAD: begin
            voice_mem[addr]  = value;
            mem_loaded[addr] = 1'b1;
         end
         OP_READ: begin
            locate_frames(offset, chan, in_range, w_lo, w_hi, frac);
            if (!in_range) begin
               ans.past_end = 1'b1;
            end else begin
               s_lo  = fetch_word(w_lo);
               s_hi  = fetch_word(w_hi);
               wt_hi = frac;
               wt_lo = UNIT_POS - frac;
               // round to nearest, halves go up: floor of (sum + half)
               acc = s_lo * wt_lo + s_hi * wt_hi + 64'sd32768;
               acc = acc >>> FRAC_BITS;
               ans.sample_out = acc[SAMPLE_BITS-1:0];
            end
            voice_answers.push_back(ans);
         end
         OP_ADVANCE: begin
            block    = {52'd0, frames} * {40'd0, cfg_rate};
            head_pos = head_pos + block;
            if (head_pos > HEAD_MAX) head_pos = HEAD_MAX;
            ans.reached_end = (head_pos + block) >= end_pos;
            end_seen = ans.reached_end;
            // looping rewinds, but the answer still reports the end
            if (cfg_looping && ans.reached_end) begin
               head_pos = '0;
               end_seen = 1'b0;
            end
            ans.is_advance = 1'b1;
            voice_answers.push_back(ans);
         end
         default: ;
      endcase
   endtask

   // compare each result word with the oldest predicted answer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_answer.sample_out  = rsp_tdata[15:0];
         got_answer.past_end    = rsp_tdata[16];
         got_answer.reached_end = rsp_tdata[17];
         got_answer.is_advance  = rsp_tuser;
         if (voice_answers.size() == 0) begin
            error_count++;
            $display("%0t: result word with no answer pending: expected none, actual %h/%b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want_answer = voice_answers.pop_front();
            compare_field("sample_out", 32'(want_answer.sample_out),
                          32'(got_answer.sample_out));
            compare_field("past_end", 32'(want_answer.past_end), 32'(got_answer.past_end));
            compare_field("reached_end", 32'(want_answer.reached_end),
                          32'(got_answer.reached_end));
            compare_field("is_advance", 32'(want_answer.is_advance),
                          32'(got_answer.is_advance));
         end
      end
   end

   // result side: long hold on request, else a rotating stall pattern
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            mode_left = $urandom_range(32, 160);
            case ($urandom_range(3))
               0:       ready_pattern = 16'hFFFF;
               1:       ready_pattern = 16'($urandom);
               2:       ready_pattern = 16'($urandom & $urandom);
               default: ready_pattern = 16'($urandom | $urandom);
            endcase
            if (ready_pattern == 0) ready_pattern = 16'h0001;
         end
         mode_left--;
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         rsp_tready <= ready_pattern[0];
      end
   end

   // offer one word, in bursts with random gaps, and predict it once taken
   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [ADDR_BITS-1:0] addr,
                            input logic [SAMPLE_BITS-1:0] value,
                            input logic [OFFSET_BITS-1:0] offset,
                            input logic [CH_BITS-1:0] chan,
                            input logic [OFFSET_BITS-1:0] frames);
      int gap;
      gap = 0;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 5);
      end
      if (gaps_off) gap = 0;
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, frames, chan, offset, value, addr};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      voice_predict(op, addr, value, offset, chan, frames);
   endtask

   task automatic load_word(input logic [ADDR_BITS-1:0] addr,
                            input logic [SAMPLE_BITS-1:0] value);
      send_item(OP_LOAD, addr, value, OFFSET_BITS'($urandom), CH_BITS'($urandom),
                OFFSET_BITS'($urandom));
   endtask

   // load any word the read would touch that was never written, then read
   task automatic read_sample(input logic [OFFSET_BITS-1:0] offset,
                              input logic [CH_BITS-1:0] chan);
      logic        in_range;
      logic [63:0] w_lo, w_hi, frac;
      locate_frames(offset, chan, in_range, w_lo, w_hi, frac);
      if (in_range) begin
         if (w_lo < SAMPLE_WORDS && !mem_loaded[w_lo[15:0]]) begin
            load_word(w_lo[15:0], SAMPLE_BITS'($urandom));
         end
         if (w_hi < SAMPLE_WORDS && !mem_loaded[w_hi[15:0]]) begin
            load_word(w_hi[15:0], SAMPLE_BITS'($urandom));
         end
      end
      send_item(OP_READ, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom), offset, chan,
                OFFSET_BITS'($urandom));
   endtask

   task automatic advance_head(input logic [OFFSET_BITS-1:0] frames);
      send_item(OP_ADVANCE, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom),
                OFFSET_BITS'($urandom), CH_BITS'($urandom), frames);
   endtask

   task automatic send_unknown();
      send_item(OP_NONE, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom),
                OFFSET_BITS'($urandom), CH_BITS'($urandom), OFFSET_BITS'($urandom));
   endtask

   // drop valid and wait until the block has nothing left in flight
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (voice_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register access: setup phase, then access phase until pready
   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, index, value, unused);
      case (index)
         REG_CHANNELS: cfg_channels = value[CC_BITS-1:0];
         REG_LENGTH:   cfg_length   = value[LEN_BITS-1:0];
         REG_RATE:     cfg_rate     = value[RATE_BITS-1:0];
         default:      cfg_looping  = value[0];
      endcase
   endtask

   task automatic check_register(input logic [1:0] index);
      logic [31:0] rdata, want;
      csr_access(1'b0, index, 32'd0, rdata);
      case (index)
         REG_CHANNELS: want = {28'd0, cfg_channels};
         REG_LENGTH:   want = {15'd0, cfg_length};
         REG_RATE:     want = {8'd0, cfg_rate};
         default:      want = {31'd0, cfg_looping};
      endcase
      compare_field("register readback", want, rdata);
   endtask

   task automatic apply_settings(input logic [CC_BITS-1:0] channels,
                                 input logic [LEN_BITS-1:0] length,
                                 input logic [RATE_BITS-1:0] rate, input logic looping);
      settle_idle();
      csr_write(REG_CHANNELS, {28'd0, channels});
      csr_write(REG_LENGTH, {15'd0, length});
      csr_write(REG_RATE, {8'd0, rate});
      csr_write(REG_LOOPING, {31'd0, looping});
   endtask

   // a maximal advance with looping on always lands on the end and rewinds
   task automatic rewind_head();
      apply_settings(cfg_channels, cfg_length, 24'hFFFFFF, 1'b1);
      advance_head(12'hFFF);
   endtask

   // one word of random traffic, mostly reads and advances near the play head
   task automatic random_item(output bit counted);
      int pick, span_words;
      logic [63:0] span;
      pick    = $urandom_range(99);
      counted = 1'b1;
      if (pick < 40) begin
         read_sample(OFFSET_BITS'(($urandom_range(4) == 0) ? $urandom_range(4095)
                                                           : $urandom_range(15)),
                     CH_BITS'($urandom_range(7)));
      end else if (pick < 55) begin
         advance_head(OFFSET_BITS'(($urandom_range(9) == 0) ? $urandom_range(4095)
                                                            : $urandom_range(7)));
      end else if (pick < 92) begin
         span = {47'd0, cfg_length} * channels_used();
         if (span == 0) span = 64'd1;
         if (span > SAMPLE_WORDS) span = 64'(SAMPLE_WORDS);
         span_words = int'(span);
         load_word(ADDR_BITS'(($urandom_range(9) < 7) ? $urandom_range(span_words - 1)
                                                      : $urandom),
                   SAMPLE_BITS'($urandom));
      end else begin
         send_unknown();
         counted = 1'b0;
      end
   endtask

   // reset values, then both extremes of each register read back
   task automatic test_registers();
      logic [1:0] reg_list [4];
      reg_list = '{REG_CHANNELS, REG_LENGTH, REG_RATE, REG_LOOPING};
      for (int i = 0; i < 4; i++) check_register(reg_list[i]);
      for (int i = 0; i < 4; i++) begin
         csr_write(reg_list[i], 32'd0);
         check_register(reg_list[i]);
         csr_write(reg_list[i], 32'hFFFF_FFFF);
         check_register(reg_list[i]);
      end
      apply_settings(CHANNELS_RESET, LENGTH_RESET, RATE_RESET, 1'b0);
   endtask

   task automatic test_directed_cases();
      // extreme samples at both ends of memory, channel clamp, unknown code
      load_word(16'd0, 16'h8000);
      load_word(16'd1, 16'h7FFF);
      load_word(16'hFFFF, 16'h7FFF);
      read_sample(12'd0, 3'd7);
      send_unknown();

      // half rate: exact half between extremes rounds up to zero
      apply_settings(4'd1, 17'd65536, 24'h008000, 1'b0);
      read_sample(12'd1, 3'd0);
      read_sample(12'hFFF, 3'd2);

      // two-frame sound at 1.5: ceiling clamp, past end, end reporting
      apply_settings(4'd1, 17'd2, 24'h018000, 1'b0);
      read_sample(12'd1, 3'd3);
      read_sample(12'd2, 3'd0);
      advance_head(12'd0);
      advance_head(12'd1);
      read_sample(12'd0, 3'd0);

      // looping rewind still reports the end
      apply_settings(4'd1, 17'd2, 24'h018000, 1'b1);
      advance_head(12'd1);
      read_sample(12'd0, 3'd0);

      // zero channels, longest sound, fastest rate: play head saturates
      apply_settings(4'd0, 17'h1FFFF, 24'hFFFFFF, 1'b0);
      advance_head(12'hFFF);
      read_sample(12'd0, 3'd5);
      read_sample(12'hFFF, 3'd5);
      apply_settings(4'd15, 17'h1FFFF, 24'hFFFFFF, 1'b1);
      advance_head(12'hFFF);

      // channel count above the maximum, last word and beyond memory
      apply_settings(4'd15, 17'd65536, 24'h010000, 1'b0);
      read_sample(12'd0, 3'd7);
      advance_head(12'hFFF);
      advance_head(12'd1);
      read_sample(12'hFFF, 3'd7);
      advance_head(12'd1);
      read_sample(12'hFFF, 3'd7);
   endtask

   // hold the result side long enough that the input stalls too
   task automatic test_backpressure();
      bit counted;
      rewind_head();
      apply_settings(4'd2, 17'd32, 24'h004000, 1'b1);
      gaps_off     = 1'b1;
      hold_request = 400;
      for (int i = 0; i < 60; i++) random_item(counted);
      gaps_off = 1'b0;
      settle_idle();
   endtask

   task automatic test_random_settings();
      bit counted;
      int sent;
      for (int phase = 0; phase < 8; phase++) begin
         rewind_head();
         case (phase)
            0: apply_settings(CHANNELS_RESET, LENGTH_RESET, RATE_RESET, 1'b0);
            1: apply_settings(4'd8, 17'd1, 24'd1, 1'b1);
            2: apply_settings(4'd15, 17'h1FFFF, 24'hFFFFFF, 1'b1);
            3: apply_settings(4'd0, 17'd0, 24'd0, 1'b0);
            4: apply_settings(4'd0, 17'd64, 24'h010000, 1'b1);
            default: apply_settings(CC_BITS'($urandom_range(1, 8)),
                                    LEN_BITS'($urandom_range(1, 200)),
                                    RATE_BITS'($urandom_range(24'h002000, 24'h030000)),
                                    $urandom_range(3) != 0);
         endcase
         sent = 0;
         while (sent < PHASE_WORDS) begin
            random_item(counted);
            if (counted) sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_registers();
      test_directed_cases();
      test_backpressure();
      test_random_settings();
      settle_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
